// ===== hdl/ecpsm_pkg.sv =====
// Shared types and constants for the elliptic-curve scalar multiplier.
`default_nettype none
package ecpsm_pkg;

    localparam int CFG_INDEX_WIDTH = 2;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_FIELD_PRIME = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CURVE_A     = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_CURVE_B     = 2'd2;

    typedef enum logic {
        MM_MUL = 1'b0,
        MM_RED = 1'b1
    } mm_op_t;

    typedef struct packed {
        logic   start;
        mm_op_t op;
    } mm_req_t;

    typedef enum logic [27:0] {
        S_IDLE     = 28'h0000001,
        S_RED_X    = 28'h0000002,
        S_RED_Y    = 28'h0000004,
        S_RED_A    = 28'h0000008,
        S_RED_B    = 28'h0000010,
        S_CHK_YY   = 28'h0000020,
        S_CHK_XX   = 28'h0000040,
        S_CHK_XXX  = 28'h0000080,
        S_CHK_AX   = 28'h0000100,
        S_CHK_SUM  = 28'h0000200,
        S_CHK_FLAG = 28'h0000400,
        S_PA       = 28'h0000800,
        S_PA_SQ    = 28'h0001000,
        S_PA_T2    = 28'h0002000,
        S_PA_T3    = 28'h0004000,
        S_PA_T4    = 28'h0008000,
        S_INV_INIT = 28'h0010000,
        S_INV_SQ   = 28'h0020000,
        S_INV_MUL  = 28'h0040000,
        S_LAM      = 28'h0080000,
        S_RX       = 28'h0100000,
        S_RX2      = 28'h0200000,
        S_RX3      = 28'h0400000,
        S_RY0      = 28'h0800000,
        S_RY       = 28'h1000000,
        S_RY2      = 28'h2000000,
        S_NEXT     = 28'h4000000,
        S_OUT      = 28'h8000000
    } state_t;

endpackage
`default_nettype wire

// ===== hdl/ecpsm_mulmod.sv =====
// Bit-serial modular multiplier and modular reducer shared by the sequencer.
`default_nettype none
module ecpsm_mulmod
    import ecpsm_pkg::*;
#(
    parameter int FIELD_WIDTH = 16
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire mm_req_t                req,
    input  wire logic [FIELD_WIDTH-1:0] opa,
    input  wire logic [FIELD_WIDTH-1:0] opb,
    input  wire logic [FIELD_WIDTH-1:0] prime,
    output logic                        done,
    output logic [FIELD_WIDTH-1:0]      result
);

    localparam int CW = (FIELD_WIDTH > 1) ? $clog2(FIELD_WIDTH) : 1;

    mm_op_t                 op_reg;
    logic [FIELD_WIDTH-1:0] a_reg;
    logic [FIELD_WIDTH-1:0] b_reg;
    logic [FIELD_WIDTH-1:0] p_reg;
    logic [FIELD_WIDTH-1:0] r_reg;
    logic [FIELD_WIDTH-1:0] r_next;
    logic [CW-1:0]          cnt_reg;
    logic                   busy_reg;
    logic                   done_reg;

    logic [FIELD_WIDTH:0]   pe;
    logic [FIELD_WIDTH:0]   t0;
    logic [FIELD_WIDTH:0]   t0m;
    logic [FIELD_WIDTH-1:0] t1;
    logic [FIELD_WIDTH:0]   s;
    logic [FIELD_WIDTH:0]   sm;
    logic [FIELD_WIDTH-1:0] t2;

    always_comb
    begin
        pe  = {1'b0, p_reg};
        t0  = (op_reg == MM_RED) ? {r_reg, a_reg[cnt_reg]} : {r_reg, 1'b0};
        t0m = t0 - pe;
        t1  = (t0 >= pe) ? t0m[FIELD_WIDTH-1:0] : t0[FIELD_WIDTH-1:0];
        s   = {1'b0, t1} + {1'b0, a_reg};
        sm  = s - pe;
        t2  = (s >= pe) ? sm[FIELD_WIDTH-1:0] : s[FIELD_WIDTH-1:0];
        r_next = ((op_reg == MM_MUL) && b_reg[cnt_reg]) ? t2 : t1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(FIELD_WIDTH - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            op_reg <= req.op;
            a_reg  <= opa;
            b_reg  <= opb;
            p_reg  <= prime;
            r_reg  <= '0;
        end
        else if (busy_reg)
        begin
            r_reg <= r_next;
        end
    end

    assign done   = done_reg;
    assign result = r_reg;

endmodule
`default_nettype wire

// ===== hdl/ec_point_scalar_multiply.sv =====
// Top level of the elliptic-curve scalar multiplier over a small prime field.
//
// Channel   Direction  Beat contents
// in        input      base_x, base_y, scalar
// out       output     result_x, result_y, at_infinity, base_on_curve
// cfg       input      cfg_index, cfg_data (field_prime, curve_a, curve_b)
//
// Every modular multiply and reduction runs through one bit-serial unit. Each point
// operation needs about FIELD_WIDTH + popcount(p-2) + 4 of them for the inverse and slope.
// The input is not ready from acceptance until the result beat is taken.
// Reset restores the default curve and leaves the block idle.
`default_nettype none
module ec_point_scalar_multiply
    import ecpsm_pkg::*;
#(
    parameter int FIELD_WIDTH  = 16,
    parameter int SCALAR_WIDTH = 16
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [FIELD_WIDTH-1:0]     base_x,
    input  wire logic [FIELD_WIDTH-1:0]     base_y,
    input  wire logic [SCALAR_WIDTH-1:0]    scalar,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic [FIELD_WIDTH-1:0]          result_x,
    output logic [FIELD_WIDTH-1:0]          result_y,
    output logic                            at_infinity,
    output logic                            base_on_curve,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [FIELD_WIDTH-1:0]     cfg_data
);

    localparam int FW  = FIELD_WIDTH;
    localparam int CW  = (FW > 1) ? $clog2(FW) : 1;
    localparam int SCW = (SCALAR_WIDTH > 1) ? $clog2(SCALAR_WIDTH) : 1;

    function automatic logic [FW-1:0] mod_add(logic [FW-1:0] u, logic [FW-1:0] v,
                                              logic [FW-1:0] p);
        logic [FW:0] sum;
        logic [FW:0] dif;
        sum = {1'b0, u} + {1'b0, v};
        dif = sum - {1'b0, p};
        return (sum >= {1'b0, p}) ? dif[FW-1:0] : sum[FW-1:0];
    endfunction

    function automatic logic [FW-1:0] mod_sub(logic [FW-1:0] u, logic [FW-1:0] v,
                                              logic [FW-1:0] p);
        logic [FW:0] wrap;
        wrap = {1'b0, u} + {1'b0, p} - {1'b0, v};
        return (u >= v) ? (u - v) : wrap[FW-1:0];
    endfunction

    state_t state_reg, state_next;

    logic [FW-1:0] p_reg, p_next;
    logic [FW-1:0] ca_reg, ca_next;
    logic [FW-1:0] cb_reg, cb_next;

    logic [FW-1:0]           gx_reg, gx_next;
    logic [FW-1:0]           gy_reg, gy_next;
    logic [SCALAR_WIDTH-1:0] k_reg, k_next;
    logic [FW-1:0]           ar_reg, ar_next;
    logic [FW-1:0]           br_reg, br_next;
    logic [FW-1:0]           accx_reg, accx_next;
    logic [FW-1:0]           accy_reg, accy_next;
    logic                    accinf_reg, accinf_next;
    logic [FW-1:0]           num_reg, num_next;
    logic [FW-1:0]           den_reg, den_next;
    logic [FW-1:0]           inv_reg, inv_next;
    logic [FW-1:0]           lam_reg, lam_next;
    logic [FW-1:0]           tmp_reg, tmp_next;
    logic [FW-1:0]           nx_reg, nx_next;
    logic [CW-1:0]           ivx_reg, ivx_next;
    logic [SCW-1:0]          bit_reg, bit_next;
    logic                    dbl_reg, dbl_next;
    logic                    run_reg, run_next;
    logic                    flag_reg, flag_next;

    logic [FW-1:0] resx_reg, resx_next;
    logic [FW-1:0] resy_reg, resy_next;
    logic          resinf_reg, resinf_next;
    logic          resflag_reg, resflag_next;

    mm_req_t       mm_req;
    logic [FW-1:0] mm_a;
    logic [FW-1:0] mm_b;
    logic          mm_done;
    logic [FW-1:0] mm_res;
    logic          mul_state;
    logic [FW-1:0] tx;
    logic [FW-1:0] ty;
    logic [FW-1:0] exp_e;
    logic          inv_last;

    ecpsm_mulmod #(
        .FIELD_WIDTH(FW)
    ) u_mulmod (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (mm_req),
        .opa    (mm_a),
        .opb    (mm_b),
        .prime  (p_reg),
        .done   (mm_done),
        .result (mm_res)
    );

    assign tx       = dbl_reg ? accx_reg : gx_reg;
    assign ty       = dbl_reg ? accy_reg : gy_reg;
    assign exp_e    = p_reg - FW'(2);
    assign inv_last = (ivx_reg == '0);

    always_comb
    begin
        mul_state = 1'b1;
        mm_req.op = MM_MUL;
        mm_a      = gx_reg;
        mm_b      = gx_reg;
        unique case (state_reg)
            S_RED_X:   begin mm_req.op = MM_RED; mm_a = gx_reg; end
            S_RED_Y:   begin mm_req.op = MM_RED; mm_a = gy_reg; end
            S_RED_A:   begin mm_req.op = MM_RED; mm_a = ca_reg; end
            S_RED_B:   begin mm_req.op = MM_RED; mm_a = cb_reg; end
            S_CHK_YY:  begin mm_a = gy_reg;   mm_b = gy_reg;   end
            S_CHK_XX:  begin mm_a = gx_reg;   mm_b = gx_reg;   end
            S_CHK_XXX: begin mm_a = tmp_reg;  mm_b = gx_reg;   end
            S_CHK_AX:  begin mm_a = ar_reg;   mm_b = gx_reg;   end
            S_PA_SQ:   begin mm_a = accx_reg; mm_b = accx_reg; end
            S_INV_SQ:  begin mm_a = inv_reg;  mm_b = inv_reg;  end
            S_INV_MUL: begin mm_a = inv_reg;  mm_b = den_reg;  end
            S_LAM:     begin mm_a = num_reg;  mm_b = inv_reg;  end
            S_RX:      begin mm_a = lam_reg;  mm_b = lam_reg;  end
            S_RY:      begin mm_a = lam_reg;  mm_b = tmp_reg;  end
            default:   mul_state = 1'b0;
        endcase
        mm_req.start = mul_state && !run_reg;
    end

    always_comb
    begin
        state_next   = state_reg;
        p_next       = p_reg;
        ca_next      = ca_reg;
        cb_next      = cb_reg;
        gx_next      = gx_reg;
        gy_next      = gy_reg;
        k_next       = k_reg;
        ar_next      = ar_reg;
        br_next      = br_reg;
        accx_next    = accx_reg;
        accy_next    = accy_reg;
        accinf_next  = accinf_reg;
        num_next     = num_reg;
        den_next     = den_reg;
        inv_next     = inv_reg;
        lam_next     = lam_reg;
        tmp_next     = tmp_reg;
        nx_next      = nx_reg;
        ivx_next     = ivx_reg;
        bit_next     = bit_reg;
        dbl_next     = dbl_reg;
        flag_next    = flag_reg;
        resx_next    = resx_reg;
        resy_next    = resy_reg;
        resinf_next  = resinf_reg;
        resflag_next = resflag_reg;
        run_next     = mm_done ? 1'b0 : (mm_req.start ? 1'b1 : run_reg);

        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_FIELD_PRIME: p_next  = cfg_data;
                CFG_CURVE_A:     ca_next = cfg_data;
                CFG_CURVE_B:     cb_next = cfg_data;
                default:         ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    gx_next = base_x;
                    gy_next = base_y;
                    k_next  = scalar;
                    if (p_reg < FW'(3))
                    begin
                        resx_next    = '0;
                        resy_next    = '0;
                        resinf_next  = 1'b0;
                        resflag_next = 1'b0;
                        state_next   = S_OUT;
                    end
                    else
                    begin
                        state_next = S_RED_X;
                    end
                end
            end
            S_RED_X:   if (mm_done) begin gx_next = mm_res; state_next = S_RED_Y; end
            S_RED_Y:   if (mm_done) begin gy_next = mm_res; state_next = S_RED_A; end
            S_RED_A:   if (mm_done) begin ar_next = mm_res; state_next = S_RED_B; end
            S_RED_B:   if (mm_done) begin br_next = mm_res; state_next = S_CHK_YY; end
            S_CHK_YY:  if (mm_done) begin num_next = mm_res; state_next = S_CHK_XX; end
            S_CHK_XX:  if (mm_done) begin tmp_next = mm_res; state_next = S_CHK_XXX; end
            S_CHK_XXX: if (mm_done) begin tmp_next = mm_res; state_next = S_CHK_AX; end
            S_CHK_AX:  if (mm_done) begin den_next = mm_res; state_next = S_CHK_SUM; end
            S_CHK_SUM:
            begin
                tmp_next   = mod_add(tmp_reg, den_reg, p_reg);
                state_next = S_CHK_FLAG;
            end
            S_CHK_FLAG:
            begin
                flag_next   = (mod_add(tmp_reg, br_reg, p_reg) == num_reg);
                accx_next   = '0;
                accy_next   = '0;
                accinf_next = 1'b1;
                bit_next    = SCW'(SCALAR_WIDTH - 1);
                dbl_next    = 1'b1;
                state_next  = S_PA;
            end
            S_PA:
            begin
                if (accinf_reg)
                begin
                    accx_next   = tx;
                    accy_next   = ty;
                    accinf_next = dbl_reg;
                    state_next  = S_NEXT;
                end
                else if (accx_reg == tx)
                begin
                    if (mod_add(accy_reg, ty, p_reg) == '0)
                    begin
                        accx_next   = '0;
                        accy_next   = '0;
                        accinf_next = 1'b1;
                        state_next  = S_NEXT;
                    end
                    else
                    begin
                        den_next   = mod_add(accy_reg, accy_reg, p_reg);
                        state_next = S_PA_SQ;
                    end
                end
                else
                begin
                    num_next   = mod_sub(ty, accy_reg, p_reg);
                    den_next   = mod_sub(tx, accx_reg, p_reg);
                    state_next = S_INV_INIT;
                end
            end
            S_PA_SQ:   if (mm_done) begin num_next = mm_res; state_next = S_PA_T2; end
            S_PA_T2:
            begin
                tmp_next   = mod_add(num_reg, num_reg, p_reg);
                state_next = S_PA_T3;
            end
            S_PA_T3:
            begin
                num_next   = mod_add(tmp_reg, num_reg, p_reg);
                state_next = S_PA_T4;
            end
            S_PA_T4:
            begin
                num_next   = mod_add(num_reg, ar_reg, p_reg);
                state_next = S_INV_INIT;
            end
            S_INV_INIT:
            begin
                inv_next   = FW'(1);
                ivx_next   = CW'(FW - 1);
                state_next = S_INV_SQ;
            end
            S_INV_SQ, S_INV_MUL:
            begin
                if (mm_done)
                begin
                    inv_next = mm_res;
                    if ((state_reg == S_INV_SQ) && exp_e[ivx_reg])
                    begin
                        state_next = S_INV_MUL;
                    end
                    else if (inv_last)
                    begin
                        state_next = S_LAM;
                    end
                    else
                    begin
                        ivx_next   = ivx_reg - 1'b1;
                        state_next = S_INV_SQ;
                    end
                end
            end
            S_LAM:     if (mm_done) begin lam_next = mm_res; state_next = S_RX; end
            S_RX:      if (mm_done) begin tmp_next = mm_res; state_next = S_RX2; end
            S_RX2:
            begin
                tmp_next   = mod_sub(tmp_reg, accx_reg, p_reg);
                state_next = S_RX3;
            end
            S_RX3:
            begin
                nx_next    = mod_sub(tmp_reg, tx, p_reg);
                state_next = S_RY0;
            end
            S_RY0:
            begin
                tmp_next   = mod_sub(accx_reg, nx_reg, p_reg);
                state_next = S_RY;
            end
            S_RY:      if (mm_done) begin tmp_next = mm_res; state_next = S_RY2; end
            S_RY2:
            begin
                accy_next   = mod_sub(tmp_reg, accy_reg, p_reg);
                accx_next   = nx_reg;
                accinf_next = 1'b0;
                state_next  = S_NEXT;
            end
            S_NEXT:
            begin
                if (dbl_reg && k_reg[bit_reg])
                begin
                    dbl_next   = 1'b0;
                    state_next = S_PA;
                end
                else if (bit_reg == '0)
                begin
                    resx_next    = accinf_reg ? '0 : accx_reg;
                    resy_next    = accinf_reg ? '0 : accy_reg;
                    resinf_next  = accinf_reg;
                    resflag_next = flag_reg;
                    state_next   = S_OUT;
                end
                else
                begin
                    bit_next   = bit_reg - 1'b1;
                    dbl_next   = 1'b1;
                    state_next = S_PA;
                end
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            p_reg     <= FW'(65521);
            ca_reg    <= '0;
            cb_reg    <= FW'(7);
            run_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            p_reg     <= p_next;
            ca_reg    <= ca_next;
            cb_reg    <= cb_next;
            run_reg   <= run_next;
        end
    end

    always_ff @(posedge clk)
    begin
        gx_reg      <= gx_next;
        gy_reg      <= gy_next;
        k_reg       <= k_next;
        ar_reg      <= ar_next;
        br_reg      <= br_next;
        accx_reg    <= accx_next;
        accy_reg    <= accy_next;
        accinf_reg  <= accinf_next;
        num_reg     <= num_next;
        den_reg     <= den_next;
        inv_reg     <= inv_next;
        lam_reg     <= lam_next;
        tmp_reg     <= tmp_next;
        nx_reg      <= nx_next;
        ivx_reg     <= ivx_next;
        bit_reg     <= bit_next;
        dbl_reg     <= dbl_next;
        flag_reg    <= flag_next;
        resx_reg    <= resx_next;
        resy_reg    <= resy_next;
        resinf_reg  <= resinf_next;
        resflag_reg <= resflag_next;
    end

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = (state_reg == S_OUT);
    assign cfg_ready     = 1'b1;
    assign result_x      = resx_reg;
    assign result_y      = resy_reg;
    assign at_infinity   = resinf_reg;
    assign base_on_curve = resflag_reg;

`ifndef SYNTH
    a_inf_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && at_infinity) |-> (result_x == '0 && result_y == '0))
        else $error("point at infinity carries nonzero coordinates");

    a_done_run: assert property (@(posedge clk) disable iff (!rst_n)
        mm_done |-> run_reg)
        else $error("multiplier finished without a pending request");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken again right after a beat");
`endif

endmodule
`default_nettype wire

// ===== tb/ec_point_scalar_multiply_tb.sv =====
// Self-checking testbench for the elliptic-curve scalar multiplier.
`timescale 1ns / 1ps
`default_nettype none
module ec_point_scalar_multiply_tb;
    import ecpsm_pkg::*;

    localparam int FW = 16;
    localparam int SW = 16;
    localparam longint CYCLE_LIMIT = 40_000_000;
    localparam int LONG_HOLD = 50_000;

    typedef struct {
        longint unsigned x;
        longint unsigned y;
        bit              inf;
    } curve_point_t;

    typedef struct {
        logic [FW-1:0] x;
        logic [FW-1:0] y;
        logic          inf;
        logic          on_curve;
    } product_t;

    typedef struct {
        logic [FW-1:0] bx;
        logic [FW-1:0] by;
        logic [SW-1:0] k;
        bit            typed;
        product_t      res;
    } vector_t;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            in_valid = 1'b0;
    logic            in_ready;
    logic [FW-1:0]   base_x = '0;
    logic [FW-1:0]   base_y = '0;
    logic [SW-1:0]   scalar = '0;
    logic            out_valid;
    logic            out_ready = 1'b0;
    logic [FW-1:0]   result_x;
    logic [FW-1:0]   result_y;
    logic            at_infinity;
    logic            base_on_curve;
    logic            cfg_valid = 1'b0;
    logic            cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = CFG_FIELD_PRIME;
    logic [FW-1:0]   cfg_data = '0;

    longint unsigned mod_p = 65521;
    longint unsigned coef_a = 0;
    longint unsigned coef_b = 7;

    product_t        pending_products[$];
    int              errors = 0;
    int              checked = 0;
    int              infinities = 0;
    int              items_sent = 0;
    longint          cycles = 0;
    bit              idling = 1'b1;
    bit              long_hold_req = 1'b0;

    ec_point_scalar_multiply #(.FIELD_WIDTH(FW), .SCALAR_WIDTH(SW)) i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .base_x(base_x), .base_y(base_y), .scalar(scalar),
        .out_valid(out_valid), .out_ready(out_ready),
        .result_x(result_x), .result_y(result_y),
        .at_infinity(at_infinity), .base_on_curve(base_on_curve),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic longint unsigned f_add(longint unsigned u, longint unsigned v,
                                              longint unsigned p);
        return (u >= p - v) ? (u - (p - v)) : (u + v);
    endfunction

    function automatic longint unsigned f_sub(longint unsigned u, longint unsigned v,
                                              longint unsigned p);
        return (u >= v) ? (u - v) : (u + (p - v));
    endfunction

    function automatic longint unsigned f_mul(longint unsigned u, longint unsigned v,
                                              longint unsigned p);
        longint unsigned r;
        r = 0;
        for (int i = FW - 1; i >= 0; i--)
        begin
            r = f_add(r, r, p);
            if (v[i])
                r = f_add(r, u, p);
        end
        return r;
    endfunction

    function automatic longint unsigned f_inv(longint unsigned u, longint unsigned p);
        longint unsigned e;
        longint unsigned r;
        e = p - 2;
        r = 1 % p;
        for (int i = FW - 1; i >= 0; i--)
        begin
            r = f_mul(r, r, p);
            if (e[i])
                r = f_mul(r, u, p);
        end
        return r;
    endfunction

    function automatic curve_point_t point_sum(curve_point_t s, curve_point_t t,
                                               longint unsigned a, longint unsigned p);
        curve_point_t r;
        longint unsigned lam;
        longint unsigned num;
        longint unsigned den;
        if (s.inf)
            return t;
        if (t.inf)
            return s;
        if (s.x == t.x)
        begin
            if (f_add(s.y, t.y, p) == 0)
            begin
                r.x = 0;
                r.y = 0;
                r.inf = 1'b1;
                return r;
            end
            num = f_mul(s.x, s.x, p);
            num = f_add(f_add(f_add(num, num, p), num, p), a, p);
            den = f_add(s.y, s.y, p);
            t = s;
        end
        else
        begin
            num = f_sub(t.y, s.y, p);
            den = f_sub(t.x, s.x, p);
        end
        lam = f_mul(num, f_inv(den, p), p);
        r.x = f_sub(f_sub(f_mul(lam, lam, p), s.x, p), t.x, p);
        r.y = f_sub(f_mul(lam, f_sub(s.x, r.x, p), p), s.y, p);
        r.inf = 1'b0;
        return r;
    endfunction

    function automatic curve_point_t point_multiple(curve_point_t g, logic [SW-1:0] k,
                                                    longint unsigned a, longint unsigned p);
        curve_point_t acc;
        acc.x = 0;
        acc.y = 0;
        acc.inf = 1'b1;
        for (int i = SW - 1; i >= 0; i--)
        begin
            acc = point_sum(acc, acc, a, p);
            if (k[i])
                acc = point_sum(acc, g, a, p);
        end
        return acc;
    endfunction

    function automatic product_t predict_product(logic [FW-1:0] bx, logic [FW-1:0] by,
                                                 logic [SW-1:0] k);
        product_t res;
        curve_point_t g;
        curve_point_t prod;
        longint unsigned a;
        longint unsigned b;
        longint unsigned lhs;
        longint unsigned rhs;
        res = '{default: '0};
        if (mod_p < 3)
            return res;
        a = coef_a % mod_p;
        b = coef_b % mod_p;
        g.x = bx % mod_p;
        g.y = by % mod_p;
        g.inf = 1'b0;
        lhs = f_mul(g.y, g.y, mod_p);
        rhs = f_mul(f_mul(g.x, g.x, mod_p), g.x, mod_p);
        rhs = f_add(f_add(rhs, f_mul(a, g.x, mod_p), mod_p), b, mod_p);
        prod = point_multiple(g, k, a, mod_p);
        res.x = prod.inf ? '0 : prod.x[FW-1:0];
        res.y = prod.inf ? '0 : prod.y[FW-1:0];
        res.inf = prod.inf;
        res.on_curve = (lhs == rhs);
        return res;
    endfunction

    task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
        $display("mismatch on %s at beat %0d: got %0d, expected %0d", field, checked, got, want);
        errors++;
    endtask

    // Receiver: random stall bursts, and one long hold on request.
    initial
    begin : receiver
        int burst;
        burst = 0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                out_ready <= 1'b0;
                for (int i = 0; i < LONG_HOLD; i++)
                    @(posedge clk);
                long_hold_req = 1'b0;
                out_ready <= 1'b1;
            end
            else if (burst > 0)
            begin
                burst--;
                out_ready <= 1'b0;
            end
            else if (idling && $urandom_range(0, 3) == 0)
            begin
                burst = $urandom_range(0, 13);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : product_check
        product_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_products.size() == 0)
            begin
                $display("result beat with no product pending");
                errors++;
            end
            else
            begin
                want = pending_products.pop_front();
                if (result_x !== want.x)
                    report_mismatch("result_x", result_x, want.x);
                if (result_y !== want.y)
                    report_mismatch("result_y", result_y, want.y);
                if (at_infinity !== want.inf)
                    report_mismatch("at_infinity", at_infinity, want.inf);
                if (base_on_curve !== want.on_curve)
                    report_mismatch("base_on_curve", base_on_curve, want.on_curve);
                if (want.inf)
                    infinities++;
            end
            checked++;
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_products.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_INDEX_WIDTH-1:0] idx, longint unsigned value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value[FW-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_FIELD_PRIME: mod_p = value[FW-1:0];
            CFG_CURVE_A:     coef_a = value[FW-1:0];
            CFG_CURVE_B:     coef_b = value[FW-1:0];
            default: ;
        endcase
    endtask

    task automatic send_point(logic [FW-1:0] bx, logic [FW-1:0] by, logic [SW-1:0] k,
                              bit typed, product_t typed_res);
        int gap;
        if (idling && $urandom_range(0, 2) == 0)
        begin
            gap = $urandom_range(1, 14);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        base_x <= bx;
        base_y <= by;
        scalar <= k;
        do
            @(posedge clk);
        while (!in_ready);
        pending_products.push_back(typed ? typed_res : predict_product(bx, by, k));
        items_sent++;
    endtask

    // Sets a curve through a chosen seed point, then sends multiples of it and some random points.
    task automatic run_curve(longint unsigned p, longint unsigned a, int count);
        curve_point_t seed;
        curve_point_t pt;
        longint unsigned b;
        logic [SW-1:0] k;
        product_t none;
        none = '{default: '0};
        seed.x = $urandom_range(0, p - 1);
        seed.y = $urandom_range(0, p - 1);
        seed.inf = 1'b0;
        b = f_sub(f_sub(f_mul(seed.y, seed.y, p), f_mul(f_mul(seed.x, seed.x, p), seed.x, p), p),
                  f_mul(a % p, seed.x, p), p);
        wait_drained();
        write_register(CFG_FIELD_PRIME, p);
        write_register(CFG_CURVE_A, a);
        write_register(CFG_CURVE_B, b);
        cfg_valid <= 1'b0;
        for (int n = 0; n < count; n++)
        begin
            k = ($urandom_range(0, 3) == 0) ? SW'($urandom_range(0, 40)) : SW'($urandom);
            if ($urandom_range(0, 4) == 0)
                send_point(FW'($urandom), FW'($urandom), k, 1'b0, none);
            else
            begin
                pt = point_multiple(seed, SW'($urandom_range(1, 65535)), a % p, p);
                if (pt.inf)
                    pt = seed;
                send_point(pt.x[FW-1:0], pt.y[FW-1:0], k, 1'b0, none);
            end
        end
    endtask

    task automatic run_noise(longint unsigned p, longint unsigned a, longint unsigned b, int count);
        product_t none;
        none = '{default: '0};
        wait_drained();
        write_register(CFG_FIELD_PRIME, p);
        write_register(CFG_CURVE_A, a);
        write_register(CFG_CURVE_B, b);
        cfg_valid <= 1'b0;
        for (int n = 0; n < count; n++)
            send_point(FW'($urandom), FW'($urandom), SW'($urandom), 1'b0, none);
    endtask

    vector_t directed[] = '{
        '{16'd0,     16'd0,     16'd0,     1'b1, '{16'd0,  16'd0, 1'b1, 1'b0}},
        '{16'hFFFF,  16'hFFFF,  16'd0,     1'b1, '{16'd0,  16'd0, 1'b1, 1'b0}},
        '{16'hFFFF,  16'hFFFF,  16'd1,     1'b1, '{16'd14, 16'd14, 1'b0, 1'b0}},
        '{16'd5,     16'd0,     16'd1,     1'b1, '{16'd5,  16'd0, 1'b0, 1'b0}},
        '{16'd65521, 16'd65521, 16'd1,     1'b1, '{16'd0,  16'd0, 1'b0, 1'b0}},
        '{16'd5,     16'd0,     16'd2,     1'b0, '{default: '0}},
        '{16'd0,     16'd0,     16'hFFFF,  1'b0, '{default: '0}},
        '{16'd1234,  16'd5678,  16'd3,     1'b0, '{default: '0}},
        '{16'd65520, 16'd1,     16'hFFFF,  1'b0, '{default: '0}},
        '{16'd777,   16'd4242,  16'h8000,  1'b0, '{default: '0}},
        '{16'h5555,  16'hAAAA,  16'hAAAA,  1'b0, '{default: '0}},
        '{16'hAAAA,  16'h5555,  16'h5555,  1'b0, '{default: '0}},
        '{16'd42,    16'd42,    16'd2,     1'b0, '{default: '0}}
    };

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        long_hold_req = 1'b1;
        foreach (directed[i])
            send_point(directed[i].bx, directed[i].by, directed[i].k,
                       directed[i].typed, directed[i].res);

        run_curve(65521, $urandom_range(0, 65520), 35);
        run_curve(17, 2, 30);
        run_curve(3, 0, 10);
        run_noise(65535, 65535, 65535, 12);
        run_noise(65521, 0, 0, 8);
        run_noise(2, 5, 9, 4);
        run_noise(0, 1, 1, 2);
        wait_drained();
        idling = 1'b0;
        run_curve(97, 96, 35);

        wait_drained();
        repeat (100) @(posedge clk);
        $display("Sent %0d points over moduli from 0 to 65535 and checked %0d products,",
                 items_sent, checked);
        $display("%0d of them at infinity, with a long output hold and random stalls.",
                 infinities);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
`default_nettype wire

// ===== files.f =====
hdl/ecpsm_pkg.sv
hdl/ecpsm_mulmod.sv
hdl/ec_point_scalar_multiply.sv
tb/ec_point_scalar_multiply_tb.sv
